@@ design/passive_device_id_sequencer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the passive device ID sequencer
// Shared forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PASSIVE_DEVICE_ID_SEQUENCER_CORE_ASSERT_SVH
`define PASSIVE_DEVICE_ID_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDIS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define PDIS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

@@ design/pdis_pkg.sv @@
// ----------------------------------------------------------------------------
// Passive device ID sequencer package
// Phase codes, type codes, pin modes and the result word layout.
// ----------------------------------------------------------------------------
package pdis_pkg;

   localparam int unsigned PhaseW = 4;
   localparam int unsigned TypeW  = 4;
   localparam int unsigned CountW = 8;
   localparam int unsigned ReqW   = 8;
   localparam int unsigned RspW   = 24;

   localparam logic [CountW-1:0] ThresholdReset = 8'd20;
   localparam logic [CountW-1:0] CountMax       = 8'd255;

   // Phases of one detection pass.
   localparam logic [PhaseW-1:0] PH_START    = 4'd0;
   localparam logic [PhaseW-1:0] PH_ID2_PRE  = 4'd1;
   localparam logic [PhaseW-1:0] PH_ID2_LOW  = 4'd2;
   localparam logic [PhaseW-1:0] PH_ID1_HIGH = 4'd3;
   localparam logic [PhaseW-1:0] PH_ID1_REL  = 4'd4;
   localparam logic [PhaseW-1:0] PH_ID2_HIGH = 4'd5;
   localparam logic [PhaseW-1:0] PH_ID1_PRE  = 4'd6;
   localparam logic [PhaseW-1:0] PH_ID1_CHK  = 4'd7;
   localparam logic [PhaseW-1:0] PH_RX_CHK   = 4'd8;
   localparam logic [PhaseW-1:0] PH_RX_DIS   = 4'd9;
   localparam logic [PhaseW-1:0] PH_TOUCH    = 4'd10;
   localparam logic [PhaseW-1:0] PH_FINAL    = 4'd11;

   // Device type codes.
   localparam logic [TypeW-1:0] TYPE_NONE    = 4'd0;
   localparam logic [TypeW-1:0] TYPE_TOUCH   = 4'd1;
   localparam logic [TypeW-1:0] TYPE_TPOINT  = 4'd2;
   localparam logic [TypeW-1:0] TYPE_3PART   = 4'd3;
   localparam logic [TypeW-1:0] TYPE_EXPLODE = 4'd4;
   localparam logic [TypeW-1:0] TYPE_UART    = 4'd5;
   localparam logic [TypeW-1:0] TYPE_TABLE   = 4'd6;

   // ID pin groups.
   localparam logic [1:0] GRP_GND  = 2'd0;
   localparam logic [1:0] GRP_VCC  = 2'd1;
   localparam logic [1:0] GRP_PULL = 2'd2;
   localparam logic [1:0] GRP_OPEN = 2'd3;

   // Pin modes.
   localparam logic [1:0] PIN_REL  = 2'd0;
   localparam logic [1:0] PIN_LOW  = 2'd1;
   localparam logic [1:0] PIN_HIGH = 2'd2;

   // Result word bit positions.
   localparam int unsigned RSP_ID1_LSB  = 0;
   localparam int unsigned RSP_ID2_LSB  = 2;
   localparam int unsigned RSP_RX_BIT   = 4;
   localparam int unsigned RSP_CAND_LSB = 5;
   localparam int unsigned RSP_HALT_BIT = 21;

   typedef struct packed {
      logic             halted;
      logic [CountW-1:0] count;
      logic [TypeW-1:0] connected;
      logic [TypeW-1:0] candidate;
      logic             rx_low;
      logic [1:0]       id2_mode;
      logic [1:0]       id1_mode;
   } rsp_fields_type;

   // Passive table entry for an ID1 group below open and an ID2 group.
   function automatic logic [TypeW-1:0] table_type(input logic [1:0] g1, input logic [1:0] g2);
      logic [TypeW-1:0] sum;
      sum = TYPE_TABLE + {1'b0, g1, 1'b0} + {2'b00, g1} + {2'b00, g2};
      return sum;
   endfunction

endpackage

@@ design/passive_device_id_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// Passive device ID sequencer
// Runs one phase of the ID pin drive-and-sample pass per tick and debounces
// the detected device type.
// ----------------------------------------------------------------------------
// Usage:
// One request is sent per sampling tick on the req_ channel and carries the
// ID1, ID2 and receive pin levels sampled on that tick plus the resume flag.
// Each request yields exactly one response on the rsp_ channel: the pin modes
// to hold until the next tick, the candidate and connected types, the match
// count, the halt flag, and rsp_tlast on the tick that ends a detection pass.
// The response appears in the cycle after the request is taken; a new request
// is taken every cycle unless the output stalls, so throughput is one request
// per clock. All phase logic sits between the state and response registers.
// The response register doubles as the output stage: req_tready stays high
// while the response is empty or being taken, and drops only while a held
// response is stalled by rsp_tready low, so nothing is lost or repeated.
// Reset clears all state but the response data, restarts the pass at its first
// phase and loads a match threshold of 20. csr_data writes the threshold at any
// csr_valid cycle; csr_ready is always high. After a UART device is connected the
// pins are released and detection stops until a request with resume set arrives.
// ----------------------------------------------------------------------------
module passive_device_id_sequencer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [0] id1_level, [1] id2_level, [2] id2_rx_level, [3] resume, [7:4] zero
   input  logic [pdis_pkg::ReqW-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [1:0] id1_drive, [3:2] id2_drive, [4] rx_pull_low, [8:5] candidate_type,
   // [12:9] connected_type, [20:13] match_count, [21] uart_handoff, [23:22] zero
   output logic [pdis_pkg::RspW-1:0]   rsp_tdata,
   output logic                        rsp_tlast,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pdis_pkg::CountW-1:0] csr_data
);
   import pdis_pkg::*;

   logic [CountW-1:0] threshold_ff;
   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [TypeW-1:0]  cand_ff, cand_in;
   logic [TypeW-1:0]  prev_ff, prev_in;
   logic [TypeW-1:0]  conn_ff, conn_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] count_inc;
   logic [1:0]        group_ff, group_in;
   logic              early_ff, early_in;
   logic              halt_ff, halt_in;
   logic [1:0]        id1m_ff, id1m_in;
   logic [1:0]        id2m_ff, id2m_in;
   logic              rxl_ff, rxl_in;
   logic              done;
   logic              rsp_valid_ff;
   logic [RspW-1:0]   rsp_data_ff;
   logic              rsp_last_ff;
   logic              req_fire;
   rsp_fields_type    fields;

   logic l1, l2, lrx, res;

   assign l1  = req_tdata[0];
   assign l2  = req_tdata[1];
   assign lrx = req_tdata[2];
   assign res = req_tdata[3];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign count_inc = (count_ff < CountMax) ? count_ff + 8'd1 : count_ff;

   always_comb begin
      phase_in = phase_ff;
      cand_in  = cand_ff;
      prev_in  = prev_ff;
      conn_in  = conn_ff;
      count_in = count_ff;
      group_in = group_ff;
      early_in = early_ff;
      halt_in  = halt_ff;
      id1m_in  = id1m_ff;
      id2m_in  = id2m_ff;
      rxl_in   = rxl_ff;
      done     = 1'b0;

      if (halt_ff) begin
         if (res) begin
            halt_in  = 1'b0;
            conn_in  = TYPE_NONE;
            count_in = '0;
            phase_in = PH_START;
         end
      end else begin
         unique case (phase_ff)
            PH_ID2_PRE: begin
               early_in = l2;
               id1m_in  = PIN_LOW;
               phase_in = PH_ID2_LOW;
            end
            PH_ID2_LOW: begin
               if (early_ff && !l2) begin
                  cand_in  = TYPE_TOUCH;
                  id1m_in  = PIN_REL;
                  phase_in = PH_TOUCH;
               end else if (!early_ff && l2) begin
                  cand_in  = TYPE_TPOINT;
                  phase_in = PH_FINAL;
               end else begin
                  early_in = l1;
                  id1m_in  = PIN_HIGH;
                  phase_in = PH_ID1_HIGH;
               end
            end
            PH_ID1_HIGH: begin
               if (early_ff && l1) begin
                  group_in = GRP_VCC;
                  phase_in = PH_ID2_HIGH;
               end else if (!early_ff && !l1) begin
                  group_in = GRP_GND;
                  phase_in = PH_ID2_HIGH;
               end else begin
                  id1m_in  = PIN_REL;
                  phase_in = PH_ID1_REL;
               end
            end
            PH_ID1_REL: begin
               group_in = l1 ? GRP_OPEN : GRP_PULL;
               phase_in = PH_ID2_HIGH;
            end
            PH_ID2_HIGH: begin
               id1m_in  = PIN_REL;
               id2m_in  = PIN_HIGH;
               phase_in = PH_ID1_PRE;
            end
            PH_ID1_PRE: begin
               early_in = l1;
               id2m_in  = PIN_LOW;
               phase_in = PH_ID1_CHK;
            end
            PH_ID1_CHK: begin
               if (early_ff && !l1) begin
                  if (group_ff == GRP_OPEN) begin
                     cand_in = TYPE_3PART;
                  end
                  phase_in = PH_FINAL;
               end else if (!early_ff && l1) begin
                  cand_in  = TYPE_EXPLODE;
                  phase_in = PH_FINAL;
               end else begin
                  id1m_in  = PIN_HIGH;
                  id2m_in  = PIN_HIGH;
                  phase_in = PH_RX_CHK;
               end
            end
            PH_RX_CHK: begin
               if (lrx) begin
                  id2m_in  = PIN_LOW;
                  rxl_in   = 1'b1;
                  phase_in = PH_RX_DIS;
               end else begin
                  cand_in  = (group_ff != GRP_OPEN) ? table_type(group_ff, GRP_GND)
                                                    : TYPE_UART;
                  phase_in = PH_FINAL;
               end
            end
            PH_RX_DIS: begin
               rxl_in = 1'b0;
               if (group_ff != GRP_OPEN) begin
                  cand_in = table_type(group_ff, lrx ? GRP_VCC : GRP_PULL);
               end
               phase_in = PH_FINAL;
            end
            PH_TOUCH: begin
               phase_in = PH_FINAL;
            end
            PH_FINAL: begin
               id2m_in = PIN_REL;
               id1m_in = PIN_HIGH;
               if (cand_ff == prev_ff) begin
                  count_in = count_inc;
                  if (count_inc >= threshold_ff) begin
                     conn_in = cand_ff;
                  end
               end else begin
                  count_in = '0;
               end
               prev_in  = cand_ff;
               done     = 1'b1;
               phase_in = PH_START;
               if (conn_in == TYPE_UART) begin
                  halt_in = 1'b1;
               end
            end
            default: begin
               // Start of pass, and recovery from any phase code outside the pass.
               cand_in  = TYPE_NONE;
               group_in = GRP_OPEN;
               id1m_in  = PIN_HIGH;
               id2m_in  = PIN_REL;
               phase_in = PH_ID2_PRE;
            end
         endcase
      end

      // The pins belong to the UART while detection is halted.
      if (halt_in) begin
         id1m_in = PIN_REL;
         id2m_in = PIN_REL;
         rxl_in  = 1'b0;
      end
   end

   always_comb begin
      fields.halted    = halt_in;
      fields.count     = count_in;
      fields.connected = conn_in;
      fields.candidate = cand_in;
      fields.rx_low    = rxl_in;
      fields.id2_mode  = id2m_in;
      fields.id1_mode  = id1m_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         phase_ff     <= PH_START;
         cand_ff      <= TYPE_NONE;
         prev_ff      <= TYPE_NONE;
         conn_ff      <= TYPE_NONE;
         count_ff     <= '0;
         group_ff     <= GRP_OPEN;
         early_ff     <= 1'b0;
         halt_ff      <= 1'b0;
         id1m_ff      <= PIN_REL;
         id2m_ff      <= PIN_REL;
         rxl_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            threshold_ff <= csr_data;
         end
         if (req_fire) begin
            phase_ff     <= phase_in;
            cand_ff      <= cand_in;
            prev_ff      <= prev_in;
            conn_ff      <= conn_in;
            count_ff     <= count_in;
            group_ff     <= group_in;
            early_ff     <= early_in;
            halt_ff      <= halt_in;
            id1m_ff      <= id1m_in;
            id2m_ff      <= id2m_in;
            rxl_ff       <= rxl_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {2'b00, fields};
         rsp_last_ff <= done;
      end
   end

endmodule

@@ design/pdis_checker.sv @@
// ----------------------------------------------------------------------------
// Passive device ID sequencer port checker
// Watches the top level ports for pin mode and flow control consistency.
// ----------------------------------------------------------------------------
`include "passive_device_id_sequencer_core_assert.svh"

module pdis_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [pdis_pkg::RspW-1:0] rsp_tdata,
   input logic                      rsp_tlast
);
   import pdis_pkg::*;

   logic [1:0] id1_drive;
   logic [1:0] id2_drive;
   logic       rx_low;
   logic       halted;

   assign id1_drive = rsp_tdata[RSP_ID1_LSB +: 2];
   assign id2_drive = rsp_tdata[RSP_ID2_LSB +: 2];
   assign rx_low    = rsp_tdata[RSP_RX_BIT];
   assign halted    = rsp_tdata[RSP_HALT_BIT];

   // While halted for the UART, every pin is released.
   `PDIS_ASSERT_SAME(a_halt_releases_pins, clock, reset, rsp_tvalid && halted,
      id1_drive == PIN_REL && id2_drive == PIN_REL && !rx_low)

   // A finished pass that does not hand off leaves ID1 high and ID2 released.
   `PDIS_ASSERT_SAME(a_pass_end_modes, clock, reset, rsp_tvalid && rsp_tlast && !halted,
      id1_drive == PIN_HIGH && id2_drive == PIN_REL)

   // The receive pin is only pulled low while ID2 is driven low.
   `PDIS_ASSERT_SAME(a_rx_low_with_id2_low, clock, reset, rsp_tvalid && rx_low,
      id2_drive == PIN_LOW)

   // An empty response stage never blocks requests.
   `PDIS_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // A taken request always produces a response in the next cycle.
   `PDIS_ASSERT_NEXT(a_request_gives_response, clock, reset, req_tvalid && req_tready,
      rsp_tvalid)

endmodule

bind passive_device_id_sequencer_core pdis_checker u_pdis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the passive device ID sequencer
// Streams sampled pin levels into the core, one request per tick. A short
// table of hand-made passes comes first and fixes two of its responses; a
// behavioral copy of the drive-and-sample pass predicts all the others.
// Random traffic follows, made mostly of pin shapes that mimic real devices,
// some held long enough to debounce. The match threshold changes between
// phases, and both sides idle at several rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import pdis_pkg::*;

   localparam int StallLimit = 2000;

   typedef struct packed {
      rsp_fields_type f;
      logic           done;
   } tick_result_type;

   typedef struct packed {
      logic            typed;
      logic [3:0]      levels;   // {resume, id2_rx_level, id2_level, id1_level}
      tick_result_type want;
   } dir_row_type;

   typedef enum int {
      SHAPE_RANDOM, SHAPE_TOUCH, SHAPE_TPOINT, SHAPE_EXPLODE,
      SHAPE_3PART, SHAPE_UART, SHAPE_TABLE
   } pin_shape_type;

   // Four hand-made passes: touch, tpoint, explode on a vcc ID1 group, and a
   // table device on a gnd ID1 group that goes through the receive discharge.
   localparam dir_row_type DirRows [27] = '{
      '{1'b1, 4'b0000, '{'{1'b0, 8'd0, TYPE_NONE, TYPE_NONE, 1'b0, PIN_REL, PIN_HIGH}, 1'b0}},
      '{1'b0, 4'b0010, '0},
      '{1'b0, 4'b1001, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b1, 4'b0000, '{'{1'b0, 8'd0, TYPE_NONE, TYPE_TOUCH, 1'b0, PIN_REL, PIN_HIGH}, 1'b1}},
      '{1'b0, 4'b1111, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0110, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0010, '0},
      '{1'b0, 4'b0011, '0},
      '{1'b0, 4'b0001, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0001, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0000, '0},
      '{1'b0, 4'b0001, '0},
      '{1'b0, 4'b0001, '0},
      '{1'b0, 4'b0100, '0},
      '{1'b0, 4'b0100, '0},
      '{1'b0, 4'b0000, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [ReqW-1:0]   req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RspW-1:0]   rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CountW-1:0] csr_data = '0;

   // Behavioral copy of the sequencer state.
   logic [PhaseW-1:0] seq_phase;
   logic [TypeW-1:0]  seq_cand;
   logic [TypeW-1:0]  seq_prev;
   logic [TypeW-1:0]  seq_conn;
   logic [CountW-1:0] seq_count;
   logic [CountW-1:0] seq_thresh;
   logic [1:0]        seq_grp1;
   logic              seq_early;
   logic              seq_halt;
   logic [1:0]        seq_id1;
   logic [1:0]        seq_id2;
   logic              seq_rx;

   tick_result_type pending_q[$];
   logic [2:0]      pin_plan [0:11];   // {rx, id2, id1} levels per phase
   int              sender_idle = 0;
   int              recv_stall = 0;
   int              mismatches = 0;
   int              quiet_cycles = 0;

   passive_device_id_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   function automatic logic [TypeW-1:0] passive_code(input logic [1:0] g2);
      return TYPE_TABLE + {2'b00, seq_grp1} * 4'd3 + {2'b00, g2};
   endfunction

   task automatic predict_tick(input logic [3:0] lv, output tick_result_type r);
      logic l1, l2, lrx, res, done;
      l1 = lv[0];
      l2 = lv[1];
      lrx = lv[2];
      res = lv[3];
      done = 1'b0;
      if (seq_halt) begin
         if (res) begin
            seq_halt = 1'b0;
            seq_conn = TYPE_NONE;
            seq_count = '0;
            seq_phase = PH_START;
         end
      end else begin
         case (seq_phase)
            PH_ID2_PRE: begin
               seq_early = l2;
               seq_id1 = PIN_LOW;
               seq_phase = PH_ID2_LOW;
            end
            PH_ID2_LOW: begin
               if (seq_early && !l2) begin
                  seq_cand = TYPE_TOUCH;
                  seq_id1 = PIN_REL;
                  seq_phase = PH_TOUCH;
               end else if (!seq_early && l2) begin
                  seq_cand = TYPE_TPOINT;
                  seq_phase = PH_FINAL;
               end else begin
                  seq_early = l1;
                  seq_id1 = PIN_HIGH;
                  seq_phase = PH_ID1_HIGH;
               end
            end
            PH_ID1_HIGH: begin
               if (seq_early && l1) begin
                  seq_grp1 = GRP_VCC;
                  seq_phase = PH_ID2_HIGH;
               end else if (!seq_early && !l1) begin
                  seq_grp1 = GRP_GND;
                  seq_phase = PH_ID2_HIGH;
               end else begin
                  seq_id1 = PIN_REL;
                  seq_phase = PH_ID1_REL;
               end
            end
            PH_ID1_REL: begin
               seq_grp1 = l1 ? GRP_OPEN : GRP_PULL;
               seq_phase = PH_ID2_HIGH;
            end
            PH_ID2_HIGH: begin
               seq_id1 = PIN_REL;
               seq_id2 = PIN_HIGH;
               seq_phase = PH_ID1_PRE;
            end
            PH_ID1_PRE: begin
               seq_early = l1;
               seq_id2 = PIN_LOW;
               seq_phase = PH_ID1_CHK;
            end
            PH_ID1_CHK: begin
               if (seq_early && !l1) begin
                  if (seq_grp1 == GRP_OPEN) seq_cand = TYPE_3PART;
                  seq_phase = PH_FINAL;
               end else if (!seq_early && l1) begin
                  seq_cand = TYPE_EXPLODE;
                  seq_phase = PH_FINAL;
               end else begin
                  seq_id1 = PIN_HIGH;
                  seq_id2 = PIN_HIGH;
                  seq_phase = PH_RX_CHK;
               end
            end
            PH_RX_CHK: begin
               if (lrx) begin
                  seq_id2 = PIN_LOW;
                  seq_rx = 1'b1;
                  seq_phase = PH_RX_DIS;
               end else begin
                  seq_cand = (seq_grp1 != GRP_OPEN) ? passive_code(GRP_GND) : TYPE_UART;
                  seq_phase = PH_FINAL;
               end
            end
            PH_RX_DIS: begin
               seq_rx = 1'b0;
               if (seq_grp1 != GRP_OPEN) seq_cand = passive_code(lrx ? GRP_VCC : GRP_PULL);
               seq_phase = PH_FINAL;
            end
            PH_TOUCH: begin
               seq_phase = PH_FINAL;
            end
            PH_FINAL: begin
               seq_id2 = PIN_REL;
               seq_id1 = PIN_HIGH;
               if (seq_cand == seq_prev) begin
                  if (seq_count < CountMax) seq_count = seq_count + 8'd1;
                  if (seq_count >= seq_thresh) seq_conn = seq_cand;
               end else begin
                  seq_count = '0;
               end
               seq_prev = seq_cand;
               done = 1'b1;
               seq_phase = PH_START;
               if (seq_conn == TYPE_UART) seq_halt = 1'b1;
            end
            default: begin
               seq_cand = TYPE_NONE;
               seq_grp1 = GRP_OPEN;
               seq_id1 = PIN_HIGH;
               seq_id2 = PIN_REL;
               seq_phase = PH_ID2_PRE;
            end
         endcase
      end
      // Pins belong to the uart while halted.
      if (seq_halt) begin
         seq_id1 = PIN_REL;
         seq_id2 = PIN_REL;
         seq_rx = 1'b0;
      end
      r.f.halted = seq_halt;
      r.f.count = seq_count;
      r.f.connected = seq_conn;
      r.f.candidate = seq_cand;
      r.f.rx_low = seq_rx;
      r.f.id2_mode = seq_id2;
      r.f.id1_mode = seq_id1;
      r.done = done;
   endtask

   task automatic send_levels(input logic [3:0] lv, input logic typed,
                              input tick_result_type given);
      tick_result_type r;
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, lv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tick(lv, r);
      pending_q.push_back(typed ? given : r);
   endtask

   task automatic drain_pending();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [CountW-1:0] value);
      drain_pending();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      seq_thresh = value;
   endtask

   task automatic set_idle(input int s, input int r);
      sender_idle = s;
      recv_stall <= r;
   endtask

   // Fills the per-phase pin levels so that a pass ends on the chosen device.
   task automatic shape_pins(input pin_shape_type shape);
      for (int p = 0; p < 12; p++) pin_plan[p] = 3'($urandom_range(7));
      if (shape == SHAPE_TOUCH) begin
         pin_plan[PH_ID2_PRE][1] = 1'b1;
         pin_plan[PH_ID2_LOW][1] = 1'b0;
      end else if (shape == SHAPE_TPOINT) begin
         pin_plan[PH_ID2_PRE][1] = 1'b0;
         pin_plan[PH_ID2_LOW][1] = 1'b1;
      end else if (shape != SHAPE_RANDOM) begin
         pin_plan[PH_ID2_LOW][1] = pin_plan[PH_ID2_PRE][1];
         case (shape)
            SHAPE_EXPLODE: begin
               pin_plan[PH_ID1_PRE][0] = 1'b0;
               pin_plan[PH_ID1_CHK][0] = 1'b1;
            end
            SHAPE_3PART: begin
               pin_plan[PH_ID1_HIGH][0] = ~pin_plan[PH_ID2_LOW][0];
               pin_plan[PH_ID1_REL][0] = 1'b1;
               pin_plan[PH_ID1_PRE][0] = 1'b1;
               pin_plan[PH_ID1_CHK][0] = 1'b0;
            end
            SHAPE_UART: begin
               pin_plan[PH_ID1_HIGH][0] = ~pin_plan[PH_ID2_LOW][0];
               pin_plan[PH_ID1_REL][0] = 1'b1;
               pin_plan[PH_ID1_CHK][0] = pin_plan[PH_ID1_PRE][0];
               pin_plan[PH_RX_CHK][2] = 1'b0;
            end
            default: begin
               pin_plan[PH_ID1_CHK][0] = pin_plan[PH_ID1_PRE][0];
               if ($urandom_range(1) == 0) begin
                  pin_plan[PH_ID1_HIGH][0] = pin_plan[PH_ID2_LOW][0];
               end else begin
                  pin_plan[PH_ID1_HIGH][0] = ~pin_plan[PH_ID2_LOW][0];
                  pin_plan[PH_ID1_REL][0] = 1'b0;
               end
            end
         endcase
      end
   endtask

   // Ticks while halted without resume are ignored by the core and not counted.
   task automatic run_traffic(input int n_items, input logic fixed, input pin_shape_type shape);
      int counted, hold;
      logic fresh, was_halted;
      logic [3:0] lv;
      counted = 0;
      hold = 0;
      fresh = 1'b1;
      while (counted < n_items) begin
         if (fresh || (hold == 0 && seq_phase == PH_START)) begin
            shape_pins(fixed ? shape : pin_shape_type'($urandom_range(6)));
            if (fixed) hold = 1000000;
            else if ($urandom_range(99) < 60) hold = $urandom_range(6, 1);
            else hold = int'(seq_thresh) + $urandom_range(4, 1);
            if (hold > 40) hold = 40;
            fresh = 1'b0;
         end
         lv[2:0] = pin_plan[seq_phase];
         if (!fixed) begin
            for (int b = 0; b < 3; b++)
               if ($urandom_range(31) == 0) lv[b] = ~lv[b];
         end
         lv[3] = seq_halt ? ($urandom_range(5) == 0) : ($urandom_range(15) == 0);
         was_halted = seq_halt;
         send_levels(lv, 1'b0, '0);
         if (!was_halted || lv[3]) counted++;
         if (pending_q[$].done && hold > 0) hold--;
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      rsp_fields_type got;
      got = rsp_tdata[RSP_HALT_BIT:0];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_q.pop_front();
            check_field("id1_drive", 8'(want.f.id1_mode), 8'(got.id1_mode));
            check_field("id2_drive", 8'(want.f.id2_mode), 8'(got.id2_mode));
            check_field("rx_pull_low", 8'(want.f.rx_low), 8'(got.rx_low));
            check_field("candidate_type", 8'(want.f.candidate), 8'(got.candidate));
            check_field("connected_type", 8'(want.f.connected), 8'(got.connected));
            check_field("match_count", want.f.count, got.count);
            check_field("uart_handoff", 8'(want.f.halted), 8'(got.halted));
            check_field("pass_done", 8'(want.done), 8'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      seq_phase = PH_START;
      seq_cand = TYPE_NONE;
      seq_prev = TYPE_NONE;
      seq_conn = TYPE_NONE;
      seq_count = '0;
      seq_thresh = ThresholdReset;
      seq_grp1 = GRP_OPEN;
      seq_early = 1'b0;
      seq_halt = 1'b0;
      seq_id1 = PIN_REL;
      seq_id2 = PIN_REL;
      seq_rx = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 27; i++)
         send_levels(DirRows[i].levels, DirRows[i].typed, DirRows[i].want);

      // The reset threshold is left in place for the first random phase.
      run_traffic(100, 1'b0, SHAPE_RANDOM);

      set_idle(56, 0);
      write_threshold(8'd1);
      run_traffic(50, 1'b0, SHAPE_RANDOM);

      // With a zero threshold, any match at all updates the connected type.
      set_idle(0, 56);
      write_threshold(8'd0);
      run_traffic(50, 1'b0, SHAPE_RANDOM);

      // A steady tpoint device for long enough to saturate the match counter.
      set_idle(37, 37);
      write_threshold(CountMax);
      run_traffic(1060, 1'b1, SHAPE_TPOINT);
      run_traffic(10, 1'b0, SHAPE_RANDOM);

      set_idle(0, 0);
      write_threshold(8'($urandom_range(12, 2)));
      run_traffic(30, 1'b0, SHAPE_RANDOM);

      drain_pending();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/pdis_pkg.sv
design/passive_device_id_sequencer_core.sv
design/pdis_checker.sv
test/tb_top.sv
